// File: src/nvtg_pkg.sv
package nvtg_pkg;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int NUM_W  = 20;
  localparam int TOK_W  = 4;
  localparam int CIT_W  = 7;
  localparam int HEX_W  = 4;

  // Defaults for the top-level parameters
  localparam int LINE_MAX_DEF        = 99;
  localparam int FRACTION_DIGITS_DEF = 3;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [CIT_W-1:0] CIT_MAX = '1;

  // Token positions within a sentence
  localparam logic [TOK_W-1:0] TOK_HEAD   = 4'd0;
  localparam logic [TOK_W-1:0] TOK_COURSE = 4'd1;
  localparam logic [TOK_W-1:0] TOK_TRUE   = 4'd2;
  localparam logic [TOK_W-1:0] TOK_MAG    = 4'd3;
  localparam logic [TOK_W-1:0] TOK_SPEED  = 4'd4;
  localparam logic [TOK_W-1:0] TOK_KNOTS  = 4'd5;
  localparam logic [TOK_W-1:0] TOK_ANY    = 4'd6;
  localparam logic [TOK_W-1:0] TOK_UNIT   = 4'd7;
  localparam logic [TOK_W-1:0] TOK_LAST   = 4'd8;
  localparam logic [TOK_W-1:0] TOK_DONE   = 4'd9;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

  // One classified character, handed from front to back
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              is_digit;
    logic              is_point;
    logic              is_comma;
    logic              is_star;
    logic              is_nl;
    logic              is_hex;
    logic [HEX_W-1:0]  hex_val;
  } char_item_t;

  // Length of each fixed-text token
  function automatic logic [2:0] token_len(input logic [TOK_W-1:0] t);
    logic [2:0] r;
    case (t)
      TOK_HEAD:  r = 3'd6;
      TOK_TRUE:  r = 3'd1;
      TOK_MAG:   r = 3'd1;
      TOK_KNOTS: r = 3'd1;
      TOK_UNIT:  r = 3'd1;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  // Expected character of a fixed-text token at a position
  function automatic logic [CHAR_W-1:0] token_char(input logic [TOK_W-1:0] t,
                                                   input logic [2:0] p);
    logic [CHAR_W-1:0] r;
    r = '0;
    case (t)
      TOK_HEAD: begin
        case (p)
          3'd0:    r = 8'h24; // $
          3'd1:    r = 8'h47; // G
          3'd2:    r = 8'h50; // P
          3'd3:    r = 8'h56; // V
          3'd4:    r = 8'h54; // T
          3'd5:    r = 8'h47; // G
          default: r = '0;
        endcase
      end
      TOK_TRUE:  r = 8'h54; // T
      TOK_MAG:   r = 8'h4D; // M
      TOK_KNOTS: r = 8'h4E; // N
      TOK_UNIT:  r = 8'h4B; // K
      default:   r = '0;
    endcase
    return r;
  endfunction

  // Powers of ten for digit weights
  function automatic logic [9:0] pow_ten(input logic [1:0] e);
    logic [9:0] r;
    case (e)
      2'd0:    r = 10'd1;
      2'd1:    r = 10'd10;
      2'd2:    r = 10'd100;
      2'd3:    r = 10'd1000;
      default: r = 10'd1;
    endcase
    return r;
  endfunction

endpackage

// File: src/nvtg_front.sv
module nvtg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_char,
  output logic                head_valid,
  output nvtg_pkg::char_item_t head_item,
  input  logic                head_pop
);

  nvtg_pkg::char_item_t cls;
  nvtg_pkg::char_item_t q_mem [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push, pop;

  // Classify the incoming character
  always_comb begin
    cls          = '0;
    cls.ch       = in_rx_char;
    cls.is_digit = (in_rx_char >= nvtg_pkg::CH_ZERO) && (in_rx_char <= nvtg_pkg::CH_NINE);
    cls.is_point = (in_rx_char == nvtg_pkg::CH_POINT);
    cls.is_comma = (in_rx_char == nvtg_pkg::CH_COMMA);
    cls.is_star  = (in_rx_char == nvtg_pkg::CH_STAR);
    cls.is_nl    = (in_rx_char == nvtg_pkg::CH_NL);
    if (cls.is_digit) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_rx_char - nvtg_pkg::CH_ZERO);
    end else if ((in_rx_char >= nvtg_pkg::CH_UA) && (in_rx_char <= nvtg_pkg::CH_UF)) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_rx_char - nvtg_pkg::CH_UA + 8'd10);
    end else if ((in_rx_char >= nvtg_pkg::CH_LA) && (in_rx_char <= nvtg_pkg::CH_LF)) begin
      cls.is_hex  = 1'b1;
      cls.hex_val = 4'(in_rx_char - nvtg_pkg::CH_LA + 8'd10);
    end
  end

  // Two-entry queue between front and back
  assign in_ready   = (cnt_r != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != 2'd0);
  assign pop        = head_valid && head_pop;
  assign head_item  = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

endmodule

// File: src/nvtg_back.sv
module nvtg_back #(
  parameter int LINE_MAX        = nvtg_pkg::LINE_MAX_DEF,
  parameter int FRACTION_DIGITS = nvtg_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  nvtg_pkg::char_item_t head_item,
  output logic                 head_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_sentence_ok,
  output logic [19:0]          out_course_milli_deg,
  output logic [19:0]          out_speed_milli_knots
);

  localparam int LEN_W = $clog2(LINE_MAX + 2);
  localparam logic [LEN_W-1:0] LINE_MAX_L = LEN_W'(LINE_MAX);
  localparam logic [1:0]       FD_L       = 2'(FRACTION_DIGITS);

  // Line parse state
  logic [LEN_W-1:0]           len_r, len_nxt;
  logic [nvtg_pkg::TOK_W-1:0] tok_r, tok_nxt;
  logic [nvtg_pkg::CIT_W-1:0] cit_r, cit_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic                       past_star_r, past_star_nxt;
  logic                       failed_r, failed_nxt;
  logic [nvtg_pkg::NUM_W-1:0] acc_r, acc_nxt;
  logic [1:0]                 fdig_r, fdig_nxt;
  logic [1:0]                 seen_r, seen_nxt;
  logic [nvtg_pkg::NUM_W-1:0] course_r, course_nxt;
  logic [nvtg_pkg::NUM_W-1:0] speed_r, speed_nxt;
  logic [7:0]                 rsum_r, rsum_nxt;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic                       ok_r, ok_nxt;
  logic [nvtg_pkg::NUM_W-1:0] ocourse_r, ocourse_nxt;
  logic [nvtg_pkg::NUM_W-1:0] ospeed_r, ospeed_nxt;

  // Datapath temporaries
  logic [nvtg_pkg::CHAR_W-1:0] c;
  logic                        first;
  logic                        numeric;
  logic [3:0]                  dig;
  logic [1:0]                  frac_exp;
  logic [24:0]                 int_sum;
  logic [20:0]                 frac_sum;
  logic [2:0]                  tlen;
  logic                        ok;

  assign c        = head_item.ch;
  assign dig      = c[3:0];
  assign frac_exp = FD_L - 2'd1 - fdig_r;
  assign int_sum  = 25'(acc_r) * 25'd10 + 25'(dig) * 25'(nvtg_pkg::pow_ten(FD_L));
  assign frac_sum = 21'(acc_r) + 21'(14'(dig) * 14'(nvtg_pkg::pow_ten(frac_exp)));
  assign tlen     = nvtg_pkg::token_len(tok_r);
  assign numeric  = (tok_r == nvtg_pkg::TOK_COURSE) || (tok_r == nvtg_pkg::TOK_SPEED);
  assign first    = (len_r == '0);

  // Stall a newline only while an untaken result sits in the output register
  assign head_pop = head_valid && (!head_item.is_nl || !out_valid_r || out_ready);

  always_comb begin
    len_nxt       = len_r;
    tok_nxt       = tok_r;
    cit_nxt       = cit_r;
    xor_nxt       = xor_r;
    past_star_nxt = past_star_r;
    failed_nxt    = failed_r;
    acc_nxt       = acc_r;
    fdig_nxt      = fdig_r;
    seen_nxt      = seen_r;
    course_nxt    = course_r;
    speed_nxt     = speed_r;
    rsum_nxt      = rsum_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ok_nxt        = ok_r;
    ocourse_nxt   = ocourse_r;
    ospeed_nxt    = ospeed_r;
    ok            = 1'b0;

    if (head_pop) begin
      // Count line length, fail long lines
      if (len_r <= LINE_MAX_L) begin
        len_nxt = len_r + 1'b1;
      end
      if (len_nxt > LINE_MAX_L) begin
        failed_nxt = 1'b1;
      end

      // Checksum covers everything after the first character up to the star
      if (head_item.is_star) begin
        past_star_nxt = 1'b1;
      end else if (!first && !past_star_r) begin
        xor_nxt = xor_r ^ c;
      end

      if (head_item.is_comma) begin
        // Close a non-empty token; empty ones vanish
        if (cit_r != '0) begin
          if (numeric) begin
            if (!seen_r[0]) begin
              failed_nxt = 1'b1;
            end else if (tok_r == nvtg_pkg::TOK_COURSE) begin
              course_nxt = acc_r;
            end else begin
              speed_nxt = acc_r;
            end
          end else if ((tok_r <= nvtg_pkg::TOK_UNIT) && (tok_r != nvtg_pkg::TOK_ANY)) begin
            if (cit_r != nvtg_pkg::CIT_W'(tlen)) begin
              failed_nxt = 1'b1;
            end
          end
          if (tok_r < nvtg_pkg::TOK_DONE) begin
            tok_nxt = tok_r + 1'b1;
          end
          cit_nxt  = '0;
          acc_nxt  = '0;
          fdig_nxt = '0;
          seen_nxt = '0;
        end
      end else begin
        // Check the character against its token
        if (tok_r > nvtg_pkg::TOK_LAST) begin
          failed_nxt = 1'b1;
        end else if (numeric) begin
          if (head_item.is_digit) begin
            if (!seen_r[1]) begin
              acc_nxt = (int_sum > 25'(nvtg_pkg::NUM_MAX)) ? nvtg_pkg::NUM_MAX
                                                          : int_sum[19:0];
            end else if (fdig_r < FD_L) begin
              acc_nxt  = (frac_sum > 21'(nvtg_pkg::NUM_MAX)) ? nvtg_pkg::NUM_MAX
                                                            : frac_sum[19:0];
              fdig_nxt = fdig_r + 1'b1;
            end
            seen_nxt[0] = 1'b1;
          end else if (head_item.is_point && !seen_r[1]) begin
            seen_nxt[1] = 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (tok_r == nvtg_pkg::TOK_LAST) begin
          if (cit_r == 7'd0) begin
            if (c != nvtg_pkg::CH_A) failed_nxt = 1'b1;
          end else if (cit_r == 7'd1) begin
            if (!head_item.is_star) failed_nxt = 1'b1;
          end else if (cit_r <= 7'd3) begin
            if (!head_item.is_hex) begin
              failed_nxt = 1'b1;
            end else begin
              rsum_nxt = {rsum_r[3:0], head_item.hex_val};
            end
          end
        end else if (tok_r != nvtg_pkg::TOK_ANY) begin
          if ((cit_r >= nvtg_pkg::CIT_W'(tlen))
              || (nvtg_pkg::token_char(tok_r, cit_r[2:0]) != c)) begin
            failed_nxt = 1'b1;
          end
        end
        if (cit_r < nvtg_pkg::CIT_MAX) begin
          cit_nxt = cit_r + 1'b1;
        end

        // Newline ends the line: report and start over
        if (head_item.is_nl) begin
          ok = !failed_nxt && (tok_r == nvtg_pkg::TOK_LAST) && (cit_nxt >= 7'd5)
               && (rsum_nxt == xor_nxt);
          out_valid_nxt = 1'b1;
          ok_nxt        = ok;
          ocourse_nxt   = ok ? course_r : '0;
          ospeed_nxt    = ok ? speed_r : '0;
          len_nxt       = '0;
          tok_nxt       = nvtg_pkg::TOK_HEAD;
          cit_nxt       = '0;
          xor_nxt       = '0;
          past_star_nxt = 1'b0;
          failed_nxt    = 1'b0;
          acc_nxt       = '0;
          fdig_nxt      = '0;
          seen_nxt      = '0;
          course_nxt    = '0;
          speed_nxt     = '0;
          rsum_nxt      = '0;
        end
      end
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    ok_r      <= ok_nxt;
    ocourse_r <= ocourse_nxt;
    ospeed_r  <= ospeed_nxt;
  end

  // Advance control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      len_r       <= '0;
      tok_r       <= nvtg_pkg::TOK_HEAD;
      cit_r       <= '0;
      xor_r       <= '0;
      past_star_r <= 1'b0;
      failed_r    <= 1'b0;
      acc_r       <= '0;
      fdig_r      <= '0;
      seen_r      <= '0;
      course_r    <= '0;
      speed_r     <= '0;
      rsum_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      tok_r       <= tok_nxt;
      cit_r       <= cit_nxt;
      xor_r       <= xor_nxt;
      past_star_r <= past_star_nxt;
      failed_r    <= failed_nxt;
      acc_r       <= acc_nxt;
      fdig_r      <= fdig_nxt;
      seen_r      <= seen_nxt;
      course_r    <= course_nxt;
      speed_r     <= speed_nxt;
      rsum_r      <= rsum_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_sentence_ok       = ok_r;
  assign out_course_milli_deg  = ocourse_r;
  assign out_speed_milli_knots = ospeed_r;

endmodule

// File: src/nmea_vtg_sentence_parser_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | in_rx_char[7:0]
// result   | out_valid / out_ready| out_sentence_ok, out_course_milli_deg[19:0],
//          |                      | out_speed_milli_knots[19:0]
//
// One character is taken per cycle while in_ready is high; the back-end parser
// handles one character per cycle out of a two-entry queue unless a newline stalls.
// A newline's result is registered: the newline is written into the queue, popped
// by the parser, and its result then loaded into the output register behind out_valid.
// Reset is synchronous, active low, and clears the queue, parser and result valid.
// A newline waits in the queue only while the previous result is not yet taken;
// other characters keep flowing, and the queue fills before in_ready drops.
module nmea_vtg_sentence_parser_top #(
  parameter int LINE_MAX        = nvtg_pkg::LINE_MAX_DEF,
  parameter int FRACTION_DIGITS = nvtg_pkg::FRACTION_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sentence_ok,
  output logic [19:0] out_course_milli_deg,
  output logic [19:0] out_speed_milli_knots
);

  logic                 head_valid;
  logic                 head_pop;
  nvtg_pkg::char_item_t head_item;

  nvtg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_char (in_rx_char),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  nvtg_back #(
    .LINE_MAX        (LINE_MAX),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (head_valid),
    .head_item             (head_item),
    .head_pop              (head_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_sentence_ok       (out_sentence_ok),
    .out_course_milli_deg  (out_course_milli_deg),
    .out_speed_milli_knots (out_speed_milli_knots)
  );

endmodule
